/* rtl/r16ie_pkg.sv */
`timescale 1ns / 1ps

package r16ie_pkg;

  // Major opcodes, instruction bits [15:13].
  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_ADDI = 3'd1,
    OP_NAND = 3'd2,
    OP_LUI  = 3'd3,
    OP_SW   = 3'd4,
    OP_LW   = 3'd5,
    OP_BEQ  = 3'd6,
    OP_JALR = 3'd7
  } opcode_t;

  localparam logic [15:0] IMM7_MASK  = 16'h007f;
  localparam logic [15:0] IMM10_MASK = 16'h03ff;

  // Everything the execute logic decides for one instruction.
  typedef struct packed {
    logic [15:0] npc;
    logic        reg_we;
    logic [15:0] wval;
    logic        is_sw;
    logic        is_lw;
    logic [15:0] ea;
    logic [15:0] sdata;
  } exec_t;

  function automatic opcode_t f_op(input logic [15:0] word);
    return opcode_t'(word[15:13]);
  endfunction

  function automatic logic [2:0] f_ra(input logic [15:0] word);
    return word[12:10];
  endfunction

  function automatic logic [2:0] f_rb(input logic [15:0] word);
    return word[9:7];
  endfunction

  function automatic logic [2:0] f_rc(input logic [15:0] word);
    return word[2:0];
  endfunction

  // Sign-extended 7-bit immediate.
  function automatic logic [15:0] f_sext7(input logic [15:0] word);
    logic [15:0] v;
    v = word & IMM7_MASK;
    return {{9{v[6]}}, v[6:0]};
  endfunction

endpackage

/* rtl/risc16_instruction_execute.sv */
`timescale 1ns / 1ps

// Channel   Dir  Signals                          Content
// --------  ---  -------------------------------  --------------------------------
// in        in   in_tvalid/in_tready/in_tdata     one instruction word per beat
// out       out  out_tvalid/out_tready/out_tdata  one result beat per instruction
//                out_tuser                        register and memory write flags
// cfg       in   cfg_wr_en/cfg_wr_data            program_words register
//
// Most instructions go from the input register to the result register in the
// next cycle. With a power-of-two DATA_WORDS, sw loads the result register
// directly and lw passes through ST_LOAD (the registered data memory read). With
// any other depth the address modulo unit adds ST_QUOT (reciprocal multiply)
// and ST_REM (remainder) first. After reset the data memory is cleared, one word
// per cycle, over all DATA_WORDS words; in_tready stays low during that pass.
// The input register takes a new beat while a result waits in the output
// register; out_tready low stalls the execute stage.
module risc16_instruction_execute import r16ie_pkg::*; #(
  parameter int DATA_WORDS = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [15:0] instruction_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [15:0] next_pc, [18:16] reg_index,
                                   // [34:19] reg_value, [50:35] mem_address,
                                   // [66:51] mem_data, [71:67] zero
  output logic [1:0]  out_tuser,   // [0] reg_write, [1] mem_write
  input  logic        cfg_wr_en,
  input  logic [16:0] cfg_wr_data  // [16:0] program_words
);

  localparam int AW = $clog2(DATA_WORDS);
  localparam bit POW2 = ((DATA_WORDS & (DATA_WORDS - 1)) == 0);
  localparam logic [28:0] RECIP = 29'(33'h1_0000_0000 / DATA_WORDS);
  localparam logic [16:0] DW17 = 17'(DATA_WORDS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(DATA_WORDS - 1);

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_RUN   = 5'b00010,
    ST_QUOT  = 5'b00100,
    ST_REM   = 5'b01000,
    ST_LOAD  = 5'b10000
  } state_t;

  state_t      st_r, st_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [16:0] pw_r;
  logic [15:0] pc_r, pc_nxt;

  // Input register.
  logic        x_valid_r;
  logic [15:0] x_word_r;
  logic [15:0] x_word;
  logic        x_fire;
  logic        out_free;

  // Memory operation in flight.
  logic [15:0] mo_npc_r, mo_npc_nxt;
  logic [2:0]  mo_ra_r, mo_ra_nxt;
  logic [15:0] mo_sd_r, mo_sd_nxt;
  logic [15:0] mo_ea_r, mo_ea_nxt;
  logic        mo_lw_r, mo_lw_nxt;
  logic [15:0] mo_ma_r, mo_ma_nxt;

  // Address modulo unit.
  logic [44:0] q_prod;
  logic [12:0] q_r;
  logic [29:0] qd;
  logic [16:0] rem_raw;
  logic [16:0] rem;
  logic [AW-1:0] rem_idx;

  // Data memory ports.
  logic [15:0] dmem [DATA_WORDS];
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [15:0]   mem_wd;
  logic [15:0]   mem_rdata_r;

  // Register file ports.
  logic        rf_we;
  logic [2:0]  rf_wa;
  logic [15:0] rf_wd;
  logic [2:0]  ra_idx;
  logic [15:0] va, vb, vc;
  exec_t       ex;

  // Output register.
  logic        out_valid_r;
  logic        out_load;
  logic [15:0] o_npc_r, o_npc_nxt;
  logic        o_rw_r, o_rw_nxt;
  logic [2:0]  o_ri_r, o_ri_nxt;
  logic [15:0] o_rv_r, o_rv_nxt;
  logic        o_mw_r, o_mw_nxt;
  logic [15:0] o_ma_r, o_ma_nxt;
  logic [15:0] o_md_r, o_md_nxt;

  // Fetch beyond the program gives a nop.
  assign x_word = ({1'b0, pc_r} >= pw_r) ? 16'h0 : x_word_r;
  assign ra_idx = f_ra(x_word);

  assign out_free  = !out_valid_r || out_tready;
  assign x_fire    = (st_r == ST_RUN) && x_valid_r && out_free;
  assign in_tready = (st_r != ST_CLEAR) && (!x_valid_r || x_fire);

  r16ie_regfile u_regfile (
    .clk   (clk),
    .rst_n (rst_n),
    .we    (rf_we),
    .wa    (rf_wa),
    .wd    (rf_wd),
    .ra_a  (ra_idx),
    .ra_b  (f_rb(x_word)),
    .ra_c  (f_rc(x_word)),
    .rd_a  (va),
    .rd_b  (vb),
    .rd_c  (vc)
  );

  r16ie_exec u_exec (
    .word (x_word),
    .pc   (pc_r),
    .va   (va),
    .vb   (vb),
    .vc   (vc),
    .res  (ex)
  );

  // Address modulo: quotient by reciprocal, then remainder with one correction.
  assign q_prod  = 45'(mo_ea_r) * 45'(RECIP);
  assign qd      = 30'(q_r) * 30'(DW17);
  assign rem_raw = {1'b0, mo_ea_r} - qd[16:0];
  assign rem     = (rem_raw >= DW17) ? (rem_raw - DW17) : rem_raw;
  assign rem_idx = rem[AW-1:0];

  // Sequencer: clearing pass, execute, and the memory operation steps.
  always_comb begin
    st_nxt       = st_r;
    clr_addr_nxt = clr_addr_r;
    pc_nxt       = pc_r;
    mem_we       = 1'b0;
    mem_wa       = '0;
    mem_wd       = 16'h0;
    mem_re       = 1'b0;
    mem_ra       = '0;
    rf_we        = 1'b0;
    rf_wa        = 3'd0;
    rf_wd        = 16'h0;
    out_load     = 1'b0;
    o_npc_nxt    = 16'h0;
    o_rw_nxt     = 1'b0;
    o_ri_nxt     = 3'd0;
    o_rv_nxt     = 16'h0;
    o_mw_nxt     = 1'b0;
    o_ma_nxt     = 16'h0;
    o_md_nxt     = 16'h0;
    mo_npc_nxt   = mo_npc_r;
    mo_ra_nxt    = mo_ra_r;
    mo_sd_nxt    = mo_sd_r;
    mo_ea_nxt    = mo_ea_r;
    mo_lw_nxt    = mo_lw_r;
    mo_ma_nxt    = mo_ma_r;
    case (st_r)
      ST_CLEAR: begin
        mem_we = 1'b1;
        mem_wa = clr_addr_r;
        if (clr_addr_r == LAST_ADDR) begin
          st_nxt = ST_RUN;
        end else begin
          clr_addr_nxt = clr_addr_r + 1'b1;
        end
      end
      ST_RUN: begin
        if (x_fire) begin
          pc_nxt = ex.npc;
          if (ex.is_sw || ex.is_lw) begin
            mo_npc_nxt = ex.npc;
            mo_ra_nxt  = ra_idx;
            mo_sd_nxt  = ex.sdata;
            mo_ea_nxt  = ex.ea;
            mo_lw_nxt  = ex.is_lw;
            mo_ma_nxt  = 16'(ex.ea[AW-1:0]);
            if (POW2) begin
              if (ex.is_lw) begin
                mem_re = 1'b1;
                mem_ra = ex.ea[AW-1:0];
                st_nxt = ST_LOAD;
              end else begin
                mem_we    = 1'b1;
                mem_wa    = ex.ea[AW-1:0];
                mem_wd    = ex.sdata;
                out_load  = 1'b1;
                o_npc_nxt = ex.npc;
                o_mw_nxt  = 1'b1;
                o_ma_nxt  = 16'(ex.ea[AW-1:0]);
                o_md_nxt  = ex.sdata;
              end
            end else begin
              st_nxt = ST_QUOT;
            end
          end else begin
            rf_we     = ex.reg_we;
            rf_wa     = ra_idx;
            rf_wd     = ex.wval;
            out_load  = 1'b1;
            o_npc_nxt = ex.npc;
            o_rw_nxt  = ex.reg_we;
            o_ri_nxt  = ex.reg_we ? ra_idx : 3'd0;
            o_rv_nxt  = ex.wval;
          end
        end
      end
      ST_QUOT: begin
        st_nxt = ST_REM;
      end
      ST_REM: begin
        mo_ma_nxt = 16'(rem_idx);
        if (mo_lw_r) begin
          mem_re = 1'b1;
          mem_ra = rem_idx;
          st_nxt = ST_LOAD;
        end else if (out_free) begin
          mem_we    = 1'b1;
          mem_wa    = rem_idx;
          mem_wd    = mo_sd_r;
          out_load  = 1'b1;
          o_npc_nxt = mo_npc_r;
          o_mw_nxt  = 1'b1;
          o_ma_nxt  = 16'(rem_idx);
          o_md_nxt  = mo_sd_r;
          st_nxt    = ST_RUN;
        end
      end
      ST_LOAD: begin
        if (out_free) begin
          rf_we     = (mo_ra_r != 3'd0);
          rf_wa     = mo_ra_r;
          rf_wd     = mem_rdata_r;
          out_load  = 1'b1;
          o_npc_nxt = mo_npc_r;
          o_rw_nxt  = (mo_ra_r != 3'd0);
          o_ri_nxt  = mo_ra_r;
          o_rv_nxt  = (mo_ra_r != 3'd0) ? mem_rdata_r : 16'h0;
          o_ma_nxt  = mo_ma_r;
          o_md_nxt  = mem_rdata_r;
          st_nxt    = ST_RUN;
        end
      end
      default: begin
        st_nxt = ST_CLEAR;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_CLEAR;
      clr_addr_r  <= '0;
      pc_r        <= 16'h0;
      pw_r        <= 17'h1_0000;
      x_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r       <= st_nxt;
      clr_addr_r <= clr_addr_nxt;
      pc_r       <= pc_nxt;
      if (cfg_wr_en) begin
        pw_r <= cfg_wr_data;
      end
      if (in_tvalid && in_tready) begin
        x_valid_r <= 1'b1;
      end else if (x_fire) begin
        x_valid_r <= 1'b0;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      x_word_r <= in_tdata;
    end
    mo_npc_r <= mo_npc_nxt;
    mo_ra_r  <= mo_ra_nxt;
    mo_sd_r  <= mo_sd_nxt;
    mo_ea_r  <= mo_ea_nxt;
    mo_lw_r  <= mo_lw_nxt;
    mo_ma_r  <= mo_ma_nxt;
    q_r      <= q_prod[44:32];
    if (out_load) begin
      o_npc_r <= o_npc_nxt;
      o_rw_r  <= o_rw_nxt;
      o_ri_r  <= o_ri_nxt;
      o_rv_r  <= o_rv_nxt;
      o_mw_r  <= o_mw_nxt;
      o_ma_r  <= o_ma_nxt;
      o_md_r  <= o_md_nxt;
    end
  end

  // Data memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_rdata_r <= dmem[mem_ra];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'b0, o_md_r, o_ma_r, o_rv_r, o_ri_r, o_npc_r};
  assign out_tuser  = {o_mw_r, o_rw_r};

endmodule

/* rtl/r16ie_regfile.sv */
`timescale 1ns / 1ps

module r16ie_regfile import r16ie_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        we,
  input  logic [2:0]  wa,
  input  logic [15:0] wd,
  input  logic [2:0]  ra_a,
  input  logic [2:0]  ra_b,
  input  logic [2:0]  ra_c,
  output logic [15:0] rd_a,
  output logic [15:0] rd_b,
  output logic [15:0] rd_c
);

  logic [15:0] regs_r [8];

  // Write port; r0 is never written and reads as zero.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) begin
        regs_r[i] <= 16'h0;
      end
    end else if (we && (wa != 3'd0)) begin
      regs_r[wa] <= wd;
    end
  end

  // Three read ports for rA, rB and rC.
  assign rd_a = (ra_a == 3'd0) ? 16'h0 : regs_r[ra_a];
  assign rd_b = (ra_b == 3'd0) ? 16'h0 : regs_r[ra_b];
  assign rd_c = (ra_c == 3'd0) ? 16'h0 : regs_r[ra_c];

endmodule

/* rtl/r16ie_exec.sv */
`timescale 1ns / 1ps

module r16ie_exec import r16ie_pkg::*; (
  input  logic [15:0] word,
  input  logic [15:0] pc,
  input  logic [15:0] va,
  input  logic [15:0] vb,
  input  logic [15:0] vc,
  output exec_t       res
);

  logic [15:0] pc1;
  logic [15:0] imm;
  logic        wr;
  logic [15:0] wval;
  opcode_t     op;

  assign pc1 = pc + 16'd1;
  assign imm = f_sext7(word);
  assign op  = f_op(word);

  // Decode and ALU.
  always_comb begin
    wr         = 1'b0;
    wval       = 16'h0;
    res        = '0;
    res.npc    = pc1;
    res.ea     = vb + imm;
    res.sdata  = va;
    case (op)
      OP_ADD: begin
        wr   = 1'b1;
        wval = vb + vc;
      end
      OP_ADDI: begin
        wr   = 1'b1;
        wval = vb + imm;
      end
      OP_NAND: begin
        wr   = 1'b1;
        wval = ~(vb & vc);
      end
      OP_LUI: begin
        wr   = 1'b1;
        wval = {word[9:0] & IMM10_MASK[9:0], 6'b0};
      end
      OP_SW: begin
        res.is_sw = 1'b1;
      end
      OP_LW: begin
        res.is_lw = 1'b1;
      end
      OP_BEQ: begin
        if (va == vb) begin
          res.npc = pc1 + imm;
        end
      end
      OP_JALR: begin
        res.npc = vb;
        wr      = 1'b1;
        wval    = pc1;
      end
      default: begin
        wr = 1'b0;
      end
    endcase
    // A write to r0 is dropped.
    res.reg_we = wr && (f_ra(word) != 3'd0);
    res.wval   = res.reg_we ? wval : 16'h0;
  end

endmodule

/* rtl/r16ie_checker.sv */
`timescale 1ns / 1ps

module r16ie_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [71:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result beat holds its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // A register write never targets r0.
  a_no_r0: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata[18:16] != 3'd0)
    else $error("register write reported for r0");

  // Without a register write the index and value read as zero.
  a_no_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[18:16] == 3'd0 && out_tdata[34:19] == 16'h0)
    else $error("register fields set without a write");

  // A store never writes a register.
  a_store_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[1] |-> !out_tuser[0])
    else $error("store reported a register write");

  // Reset empties the output register.
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

endmodule

bind risc16_instruction_execute r16ie_checker u_r16ie_checker (.*);

/* bench/risc16_instruction_execute_tb.sv */
`timescale 1ns / 1ps

module risc16_instruction_execute_tb;
  import r16ie_pkg::*;

  localparam int DATA_WORDS = 4096;
  localparam int STALL_LIMIT = 20000;
  localparam int ITEMS_PER_PHASE = 62;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_OFF_AT = 150;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam logic [16:0] FULL_SPACE = 17'h10000;

  // One retired instruction as the block reports it.
  typedef struct {
    logic [15:0] next_pc;
    logic        reg_write;
    logic [2:0]  reg_index;
    logic [15:0] reg_value;
    logic        mem_write;
    logic [15:0] mem_address;
    logic [15:0] mem_data;
  } retire_t;

  // Architectural model of the processor plus the queue of retirements it predicts.
  class r16_scoreboard;
    logic [15:0] regs [8];
    logic [15:0] pc;
    logic [15:0] dmem [DATA_WORDS];
    logic [16:0] prog_words;
    retire_t     retire_q [$];
    int          errors;

    function new();
      foreach (regs[i]) regs[i] = '0;
      foreach (dmem[i]) dmem[i] = '0;
      pc = '0;
      prog_words = FULL_SPACE;
      errors = 0;
    endfunction

    function void set_program_words(input logic [16:0] words);
      prog_words = words;
    endfunction

    function int pending();
      return retire_q.size();
    endfunction

    // Execute one accepted instruction beat and queue what it should retire as.
    function void note_instruction(input logic [15:0] word_in);
      retire_t     r;
      logic [15:0] word, pc1, npc, vb, vc, imm, ea, wval;
      logic [31:0] addr;
      logic [2:0]  ra, rb, rc;
      logic        wr;
      opcode_t     op;
      // Fetches past the end of the program read as a nop.
      word = ({1'b0, pc} >= prog_words) ? 16'h0000 : word_in;
      op = opcode_t'(word[15:13]);
      ra = word[12:10];
      rb = word[9:7];
      rc = word[2:0];
      vb = regs[rb];
      vc = regs[rc];
      imm = {{9{word[6]}}, word[6:0]};
      pc1 = pc + 16'd1;
      npc = pc1;
      wr = 1'b0;
      wval = '0;
      ea = vb + imm;
      addr = 32'(ea) % DATA_WORDS;
      r.mem_write = 1'b0;
      r.mem_address = '0;
      r.mem_data = '0;
      case (op)
        OP_ADD: begin
          wr = 1'b1;
          wval = vb + vc;
        end
        OP_ADDI: begin
          wr = 1'b1;
          wval = vb + imm;
        end
        OP_NAND: begin
          wr = 1'b1;
          wval = ~(vb & vc);
        end
        OP_LUI: begin
          wr = 1'b1;
          wval = {word[9:0], 6'b0};
        end
        OP_SW: begin
          r.mem_write = 1'b1;
          r.mem_address = addr[15:0];
          r.mem_data = regs[ra];
          dmem[addr] = regs[ra];
        end
        OP_LW: begin
          r.mem_address = addr[15:0];
          r.mem_data = dmem[addr];
          wr = 1'b1;
          wval = dmem[addr];
        end
        OP_BEQ: begin
          if (regs[ra] == vb) npc = pc1 + imm;
        end
        default: begin
          npc = vb;
          wr = 1'b1;
          wval = pc1;
        end
      endcase
      // Writes to r0 are dropped, and the report shows no write at all.
      if (ra == 3'd0) wr = 1'b0;
      if (wr) regs[ra] = wval;
      pc = npc;
      r.next_pc = npc;
      r.reg_write = wr;
      r.reg_index = wr ? ra : 3'd0;
      r.reg_value = wr ? wval : 16'h0000;
      retire_q.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%04h, got 0x%04h", name, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat against the oldest queued retirement.
    function void check_result(input logic [71:0] tdata, input logic [1:0] tuser);
      retire_t r;
      if (retire_q.size() == 0) begin
        $error("result beat with no instruction outstanding: tdata 0x%018h", tdata);
        errors++;
        return;
      end
      r = retire_q.pop_front();
      compare_field("next_pc", r.next_pc, tdata[15:0]);
      compare_field("reg_write", 16'(r.reg_write), 16'(tuser[0]));
      compare_field("reg_index", 16'(r.reg_index), 16'(tdata[18:16]));
      compare_field("reg_value", r.reg_value, tdata[34:19]);
      compare_field("mem_write", 16'(r.mem_write), 16'(tuser[1]));
      compare_field("mem_address", r.mem_address, tdata[50:35]);
      compare_field("mem_data", r.mem_data, tdata[66:51]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [71:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        cfg_wr_en;
  logic [16:0] cfg_wr_data;

  r16_scoreboard sb;
  int          idle_cycles;
  int          tx_burst;
  int          rx_burst;
  int          rx_count;
  logic [16:0] phase_words [7];

  risc16_instruction_execute #(
    .DATA_WORDS(DATA_WORDS)
  ) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always #1 clk = ~clk;

  // Gap before the next beat; occasional runs of back-to-back beats.
  function automatic int draw_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) burst = $urandom_range(8, 30);
    return $urandom_range(0, 15);
  endfunction

  // Assemble an instruction; lui takes its 10-bit immediate as {rb, low7}.
  function automatic logic [15:0] mk(input opcode_t op, input logic [2:0] ra,
                                     input logic [2:0] rb, input logic [6:0] low7);
    return {op, ra, rb, low7};
  endfunction

  // Mostly well-formed instructions with r0 as the base half the time, so that
  // loads hit earlier stores and jumps return to low addresses; some raw noise.
  function automatic logic [15:0] random_instruction();
    logic [2:0] rb;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    rb = ($urandom_range(0, 1) == 0) ? 3'd0 : 3'($urandom_range(0, 7));
    return mk(opcode_t'($urandom_range(0, 7)), 3'($urandom_range(0, 7)), rb,
              7'($urandom_range(0, 127)));
  endfunction

  // Offer one instruction beat and wait until it is taken.
  task automatic send_word(input logic [15:0] word);
    int gap;
    gap = draw_gap(tx_burst);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= word;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_instruction(word);
    @(negedge clk);
  endtask

  // Let every outstanding instruction retire, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_program_words(input logic [16:0] words);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= words;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_program_words(words);
  endtask

  // Stall watchdog: no beat on either side for too long ends the run.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("** risc16_instruction_execute: FAILED **");
      $finish;
    end
  end

  // Result side: random back-pressure with one long hold-off to fill the block.
  initial begin
    int gap;
    out_tready = 1'b0;
    rx_burst = 0;
    rx_count = 0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      gap = draw_gap(rx_burst);
      if (rx_count == HOLD_OFF_AT) gap = HOLD_OFF_CYCLES;
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
      sb.check_result(out_tdata, out_tuser);
      rx_count++;
      @(negedge clk);
    end
  end

  // Stimulus: directed instructions, then random phases under several program sizes.
  initial begin
    logic [15:0] directed [$];
    clk = 1'b0;
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    idle_cycles = 0;
    tx_burst = 0;
    sb = new();
    phase_words[0] = FULL_SPACE;
    phase_words[1] = 17'd1;
    phase_words[2] = 17'd0;
    phase_words[3] = 17'd48;
    phase_words[4] = 17'h1ffff;
    phase_words[5] = 17'h0ffff;
    phase_words[6] = 17'($urandom_range(2, 65535));

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Extremes of every field, each opcode, r0 writes, address and pc wrap.
    directed = '{
      mk(OP_ADD, 3'd0, 3'd0, 7'h00),
      mk(OP_LUI, 3'd1, 3'd7, 7'h7f),
      mk(OP_ADDI, 3'd1, 3'd1, 7'h3f),
      mk(OP_ADDI, 3'd2, 3'd0, 7'h40),
      mk(OP_ADD, 3'd3, 3'd1, 7'h02),
      mk(OP_NAND, 3'd4, 3'd1, 7'h03),
      mk(OP_SW, 3'd1, 3'd2, 7'h7f),
      mk(OP_LW, 3'd5, 3'd2, 7'h7f),
      mk(OP_LW, 3'd0, 3'd2, 7'h7f),
      mk(OP_ADDI, 3'd0, 3'd1, 7'h05),
      mk(OP_SW, 3'd4, 3'd0, 7'h3f),
      mk(OP_BEQ, 3'd5, 3'd1, 7'h02),
      mk(OP_BEQ, 3'd0, 3'd1, 7'h40),
      mk(OP_JALR, 3'd6, 3'd1, 7'h00),
      mk(OP_BEQ, 3'd0, 3'd0, 7'h01),
      mk(OP_JALR, 3'd7, 3'd0, 7'h00),
      mk(OP_LW, 3'd7, 3'd0, 7'h40),
      mk(OP_NAND, 3'd7, 3'd7, 7'h7f),
      16'hffff,
      mk(OP_LUI, 3'd7, 3'd0, 7'h00),
      mk(OP_JALR, 3'd0, 3'd0, 7'h00)
    };
    foreach (directed[i]) send_word(directed[i]);

    // Each phase first jumps back to address zero, then sets the program size.
    foreach (phase_words[p]) begin
      wait_idle();
      write_program_words(FULL_SPACE);
      send_word(mk(OP_JALR, 3'd0, 3'd0, 7'h00));
      wait_idle();
      write_program_words(phase_words[p]);
      repeat (ITEMS_PER_PHASE) send_word(random_instruction());
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) begin
      $display("** risc16_instruction_execute: PASSED **");
    end else begin
      $display("** risc16_instruction_execute: FAILED **");
    end
    $finish;
  end

endmodule
